// ----- sv/ljpfa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpfa_pkg
// Shared types and constants of the Lennard-Jones pair force accumulator.
// ----------------------------------------------------------------------------
package ljpfa_pkg;

    // particle store geometry
    localparam int MAX_PARTICLES = 1024;
    localparam int PART_AW       = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

    // fixed point widths
    localparam int FORCE_W = 48;
    localparam int ENTRY_W = 3 * FORCE_W;
    localparam int CFG_W   = 31;

    // lower bound on r^2 (0.2 in Q15.16)
    localparam logic [48:0] RMIN2 = 49'd13107;

    // operation codes
    localparam logic [1:0] FN_CLEAR  = 2'd0;
    localparam logic [1:0] FN_PAIR   = 2'd1;
    localparam logic [1:0] FN_READ   = 2'd2;
    localparam logic [1:0] FN_ENERGY = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_BOX_LENGTH    = 2'd0;
    localparam logic [1:0] CFG_CUTOFF_SQ     = 2'd1;
    localparam logic [1:0] CFG_SIGMA_SQ      = 2'd2;
    localparam logic [1:0] CFG_EPSILON_DEPTH = 2'd3;

    // configuration reset values
    localparam logic [30:0] BOX_LENGTH_RST    = 31'd655360;
    localparam logic [30:0] CUTOFF_SQ_RST     = 31'd409600;
    localparam logic [30:0] SIGMA_SQ_RST      = 31'd65536;
    localparam logic [30:0] EPSILON_DEPTH_RST = 31'd65536;

    // input beat
    typedef struct packed {
        logic        [1:0]  func;
        logic        [9:0]  index_a;
        logic        [9:0]  index_b;
        logic signed [31:0] pos_a_x;
        logic signed [31:0] pos_a_y;
        logic signed [31:0] pos_a_z;
        logic signed [31:0] pos_b_x;
        logic signed [31:0] pos_b_y;
        logic signed [31:0] pos_b_z;
    } ljpfa_in_t;

    // result beat
    typedef struct packed {
        logic signed [47:0] out_force_x;
        logic signed [47:0] out_force_y;
        logic signed [47:0] out_force_z;
        logic signed [47:0] energy_total;
        logic               pair_applied;
    } ljpfa_out_t;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_MOD_GO,
        S_MOD_WAIT,
        S_MUL_GO,
        S_MUL_WAIT,
        S_RANGE,
        S_DIVI_GO,
        S_DIVI_WAIT,
        S_DIVS_GO,
        S_DIVS_WAIT,
        S_RD_A,
        S_UPD_A,
        S_RD_B,
        S_UPD_B,
        S_RD_OP,
        S_RD_DATA,
        S_RESP
    } ljpfa_state_t;

    // multiply steps of the force evaluation
    typedef enum logic [3:0] {
        M_SQX,
        M_SQY,
        M_SQZ,
        M_SS,
        M_SR6,
        M_SR12,
        M_ET,
        M_FI,
        M_FX,
        M_FY,
        M_FZ,
        M_EU
    } ljpfa_mop_t;

endpackage

// ----- sv/ljpfa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpfa_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ljpfa_ram #(
    parameter int WIDTH = 144,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- sv/lennard_jones_pair_force_accumulator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lennard_jones_pair_force_accumulator
// Lennard-Jones 12-6 pair force with cutoff, accumulated per particle.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready carry one beat per operation: clear force, pair, read
//   force or reset energy. m_valid/m_ready return exactly one result beat
//   for every input beat, in order. cfg_valid/cfg_ready write the box
//   length, cutoff, sigma^2 and epsilon registers; cfg_ready is always high.
//   The user must make writes only while the block is idle; the block
//   itself does not enforce this. One operation is in flight at a time.
//   A pair inside the cutoff runs three 48-step remainder passes for the
//   box wrap (skipped with a box length of zero), two 48-step divisions
//   for 1/r^2 and sigma^2/r^2, and twelve multiplies on one shared 48x16
//   multiplier, then a read-modify-write of the two force entries. A pair
//   beyond the cutoff finishes after the r^2 test. Forces live in one RAM
//   of MAX_PARTICLES entries; entries hold garbage until cleared. Reset
//   clears the energy total and restores the configuration registers. The
//   result sits in an output register, so the next beat is accepted while
//   a stalled result waits for m_ready.
// ----------------------------------------------------------------------------
module lennard_jones_pair_force_accumulator (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ljpfa_pkg::ljpfa_in_t   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ljpfa_pkg::ljpfa_out_t  m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data
);

    localparam logic signed [52:0] SAT_HI = 53'sd140737488355327;
    localparam logic signed [52:0] SAT_LO = -53'sd140737488355328;
    localparam logic [46:0]        MAG_MAX = {47{1'b1}};
    localparam logic [5:0]         DIV_LAST = 6'd47;
    localparam logic [1:0]         MUL_LAST = 2'd2;

    // saturate to 48 bit signed
    function automatic logic signed [47:0] sat48(input logic signed [52:0] v);
        logic signed [47:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[47:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[47:0];
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    function automatic logic signed [52:0] ext53(input logic signed [47:0] v);
        return $signed({{5{v[47]}}, v});
    endfunction

    function automatic logic [47:0] abs48(input logic signed [47:0] v);
        return v[47] ? 48'(-v) : 48'(v);
    endfunction

    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic signed [47:0] signed_mag(input logic [46:0] m,
                                                      input logic neg);
        logic signed [47:0] p;
        p = $signed({1'b0, m});
        return neg ? -p : p;
    endfunction

    // control and item registers
    ljpfa_pkg::ljpfa_state_t state_reg, state_next;
    ljpfa_pkg::ljpfa_mop_t   mop_reg;
    ljpfa_pkg::ljpfa_in_t    item_reg;
    ljpfa_pkg::ljpfa_out_t   m_data_reg;
    logic                    m_valid_reg;
    logic [1:0]              axis_reg;

    // configuration
    logic [30:0] box_length_reg, cutoff_sq_reg, sigma_sq_reg, epsilon_depth_reg;

    // datapath registers
    logic signed [32:0] d_reg [3];
    logic [48:0]        r2_reg;
    logic [30:0]        rdiv_reg;
    logic [18:0]        inv_reg;
    logic [33:0]        s_reg;
    logic [46:0]        ss_reg, sr6_reg, sr12_reg;
    logic signed [47:0] fr1_reg, fr2_reg, u_reg;
    logic signed [47:0] f_reg [3];
    logic signed [47:0] energy_reg;
    logic               applied_reg;

    // divider
    logic        div_start, div_busy_reg, div_done_reg;
    logic [47:0] div_dvd, div_q_reg;
    logic [30:0] div_dvs, div_dvs_reg, div_rem_reg;
    logic [5:0]  div_cnt_reg;
    logic [31:0] div_rem_sh;

    // multiplier
    logic        mul_start, mul_busy_reg, mul_done_reg;
    logic [47:0] mul_a, mul_b, mul_a_reg, mul_b_reg;
    logic [95:0] mul_acc_reg;
    logic [1:0]  mul_cnt_reg;
    logic [63:0] mul_pp;
    logic [46:0] mul_res;

    // force store
    logic                                   ram_we;
    logic [ljpfa_pkg::PART_AW-1:0]          ram_waddr, ram_raddr;
    logic [ljpfa_pkg::ENTRY_W-1:0]          ram_wdata, ram_rdata;
    logic signed [47:0]                     old_x, old_y, old_z;

    // decode helpers
    logic               in_range_a, pair_ok, in_cut, out_free;
    logic [48:0]        r2_floor;
    logic signed [32:0] d_axis, wrap_val;
    logic [31:0]        wrap_r1;
    logic signed [49:0] t_wide;
    logic signed [47:0] t_val, v_val;
    logic               mul_neg;
    logic signed [47:0] mul_sgn;
    logic signed [52:0] mul_sx;

    assign s_ready   = (state_reg == ljpfa_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    assign in_range_a = 32'(item_reg.index_a) < ljpfa_pkg::MAX_PARTICLES;
    assign pair_ok    = (item_reg.index_b > item_reg.index_a)
                     && (32'(item_reg.index_b) < ljpfa_pkg::MAX_PARTICLES);

    // r^2 floor and cutoff test
    assign r2_floor = (r2_reg < ljpfa_pkg::RMIN2) ? ljpfa_pkg::RMIN2 : r2_reg;
    assign in_cut   = r2_floor <= {18'd0, cutoff_sq_reg};

    // minimum image fix-up of the remainder
    assign d_axis  = d_reg[axis_reg];
    assign wrap_r1 = (d_axis[32] && (div_rem_reg != '0))
                   ? ({1'b0, box_length_reg} - {1'b0, div_rem_reg})
                   : {1'b0, div_rem_reg};
    always_comb begin
        if ({wrap_r1, 1'b0} > {2'b00, box_length_reg}) begin
            wrap_val = $signed({1'b0, wrap_r1} - {2'b00, box_length_reg});
        end else begin
            wrap_val = $signed({1'b0, wrap_r1});
        end
    end

    // lj terms
    assign t_wide = $signed({2'b00, sr12_reg, 1'b0}) - $signed({3'b000, sr6_reg});
    assign t_val  = sat48($signed({{3{t_wide[49]}}, t_wide}));
    assign v_val  = $signed({1'b0, sr12_reg}) - $signed({1'b0, sr6_reg});

    // sign of the current multiply result
    always_comb begin
        case (mop_reg)
            ljpfa_pkg::M_ET: mul_neg = t_val[47];
            ljpfa_pkg::M_FI: mul_neg = fr1_reg[47];
            ljpfa_pkg::M_FX: mul_neg = fr2_reg[47] ^ d_reg[0][32];
            ljpfa_pkg::M_FY: mul_neg = fr2_reg[47] ^ d_reg[1][32];
            ljpfa_pkg::M_FZ: mul_neg = fr2_reg[47] ^ d_reg[2][32];
            ljpfa_pkg::M_EU: mul_neg = v_val[47];
            default:         mul_neg = 1'b0;
        endcase
    end
    assign mul_sgn = signed_mag(mul_res, mul_neg);
    assign mul_sx  = ext53(mul_sgn);

    assign old_x = ram_rdata[47:0];
    assign old_y = ram_rdata[95:48];
    assign old_z = ram_rdata[143:96];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ljpfa_pkg::S_IDLE: begin
                if (s_valid) state_next = ljpfa_pkg::S_DECODE;
            end
            ljpfa_pkg::S_DECODE: begin
                case (item_reg.func)
                    ljpfa_pkg::FN_READ:
                        state_next = in_range_a ? ljpfa_pkg::S_RD_OP : ljpfa_pkg::S_RESP;
                    ljpfa_pkg::FN_PAIR: begin
                        if (!pair_ok) begin
                            state_next = ljpfa_pkg::S_RESP;
                        end else if (box_length_reg == '0) begin
                            state_next = ljpfa_pkg::S_MUL_GO;
                        end else begin
                            state_next = ljpfa_pkg::S_MOD_GO;
                        end
                    end
                    default: state_next = ljpfa_pkg::S_RESP;
                endcase
            end
            ljpfa_pkg::S_MOD_GO: state_next = ljpfa_pkg::S_MOD_WAIT;
            ljpfa_pkg::S_MOD_WAIT: begin
                if (div_done_reg) begin
                    state_next = (axis_reg == 2'd2) ? ljpfa_pkg::S_MUL_GO
                                                    : ljpfa_pkg::S_MOD_GO;
                end
            end
            ljpfa_pkg::S_MUL_GO: state_next = ljpfa_pkg::S_MUL_WAIT;
            ljpfa_pkg::S_MUL_WAIT: begin
                if (mul_done_reg) begin
                    case (mop_reg)
                        ljpfa_pkg::M_SQZ: state_next = ljpfa_pkg::S_RANGE;
                        ljpfa_pkg::M_EU:  state_next = ljpfa_pkg::S_RD_A;
                        default:          state_next = ljpfa_pkg::S_MUL_GO;
                    endcase
                end
            end
            ljpfa_pkg::S_RANGE:
                state_next = in_cut ? ljpfa_pkg::S_DIVI_GO : ljpfa_pkg::S_RESP;
            ljpfa_pkg::S_DIVI_GO: state_next = ljpfa_pkg::S_DIVI_WAIT;
            ljpfa_pkg::S_DIVI_WAIT: begin
                if (div_done_reg) state_next = ljpfa_pkg::S_DIVS_GO;
            end
            ljpfa_pkg::S_DIVS_GO: state_next = ljpfa_pkg::S_DIVS_WAIT;
            ljpfa_pkg::S_DIVS_WAIT: begin
                if (div_done_reg) state_next = ljpfa_pkg::S_MUL_GO;
            end
            ljpfa_pkg::S_RD_A:    state_next = ljpfa_pkg::S_UPD_A;
            ljpfa_pkg::S_UPD_A:   state_next = ljpfa_pkg::S_RD_B;
            ljpfa_pkg::S_RD_B:    state_next = ljpfa_pkg::S_UPD_B;
            ljpfa_pkg::S_UPD_B:   state_next = ljpfa_pkg::S_RESP;
            ljpfa_pkg::S_RD_OP:   state_next = ljpfa_pkg::S_RD_DATA;
            ljpfa_pkg::S_RD_DATA: state_next = ljpfa_pkg::S_RESP;
            ljpfa_pkg::S_RESP: begin
                if (out_free) state_next = ljpfa_pkg::S_IDLE;
            end
            default: state_next = ljpfa_pkg::S_IDLE;
        endcase
    end

    // unit strobes, operands and memory port
    always_comb begin
        div_start = 1'b0;
        div_dvd   = 48'(abs33(d_axis));
        div_dvs   = box_length_reg;
        mul_start = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = ljpfa_pkg::PART_AW'(item_reg.index_a);
        ram_wdata = '0;
        ram_raddr = ljpfa_pkg::PART_AW'(item_reg.index_a);
        case (state_reg)
            ljpfa_pkg::S_DECODE: begin
                ram_we = (item_reg.func == ljpfa_pkg::FN_CLEAR) && in_range_a;
            end
            ljpfa_pkg::S_MOD_GO: div_start = 1'b1;
            ljpfa_pkg::S_DIVI_GO: begin
                div_start = 1'b1;
                div_dvd   = 48'h0001_0000_0000;
                div_dvs   = rdiv_reg;
            end
            ljpfa_pkg::S_DIVS_GO: begin
                div_start = 1'b1;
                div_dvd   = {1'b0, sigma_sq_reg, 16'd0};
                div_dvs   = rdiv_reg;
            end
            ljpfa_pkg::S_MUL_GO: mul_start = 1'b1;
            ljpfa_pkg::S_UPD_A: begin
                ram_we    = 1'b1;
                ram_wdata = {sat48(ext53(old_z) + ext53(f_reg[2])),
                             sat48(ext53(old_y) + ext53(f_reg[1])),
                             sat48(ext53(old_x) + ext53(f_reg[0]))};
            end
            ljpfa_pkg::S_RD_B: begin
                ram_raddr = ljpfa_pkg::PART_AW'(item_reg.index_b);
            end
            ljpfa_pkg::S_UPD_B: begin
                ram_we    = 1'b1;
                ram_waddr = ljpfa_pkg::PART_AW'(item_reg.index_b);
                ram_wdata = {sat48(ext53(old_z) - ext53(f_reg[2])),
                             sat48(ext53(old_y) - ext53(f_reg[1])),
                             sat48(ext53(old_x) - ext53(f_reg[0]))};
            end
            default: ;
        endcase
    end

    // multiplier operands per step
    always_comb begin
        case (mop_reg)
            ljpfa_pkg::M_SQX: begin
                mul_a = 48'(abs33(d_reg[0]));
                mul_b = 48'(abs33(d_reg[0]));
            end
            ljpfa_pkg::M_SQY: begin
                mul_a = 48'(abs33(d_reg[1]));
                mul_b = 48'(abs33(d_reg[1]));
            end
            ljpfa_pkg::M_SQZ: begin
                mul_a = 48'(abs33(d_reg[2]));
                mul_b = 48'(abs33(d_reg[2]));
            end
            ljpfa_pkg::M_SS: begin
                mul_a = 48'(s_reg);
                mul_b = 48'(s_reg);
            end
            ljpfa_pkg::M_SR6: begin
                mul_a = 48'(ss_reg);
                mul_b = 48'(s_reg);
            end
            ljpfa_pkg::M_SR12: begin
                mul_a = 48'(sr6_reg);
                mul_b = 48'(sr6_reg);
            end
            ljpfa_pkg::M_ET: begin
                mul_a = 48'(epsilon_depth_reg);
                mul_b = abs48(t_val);
            end
            ljpfa_pkg::M_FI: begin
                mul_a = abs48(fr1_reg);
                mul_b = 48'(inv_reg);
            end
            ljpfa_pkg::M_FX: begin
                mul_a = abs48(fr2_reg);
                mul_b = 48'(abs33(d_reg[0]));
            end
            ljpfa_pkg::M_FY: begin
                mul_a = abs48(fr2_reg);
                mul_b = 48'(abs33(d_reg[1]));
            end
            ljpfa_pkg::M_FZ: begin
                mul_a = abs48(fr2_reg);
                mul_b = 48'(abs33(d_reg[2]));
            end
            ljpfa_pkg::M_EU: begin
                mul_a = 48'(epsilon_depth_reg);
                mul_b = abs48(v_val);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // state register and output beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ljpfa_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ljpfa_pkg::S_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ljpfa_pkg::S_RESP && out_free) begin
            m_data_reg.out_force_x  <= f_reg[0];
            m_data_reg.out_force_y  <= f_reg[1];
            m_data_reg.out_force_z  <= f_reg[2];
            m_data_reg.energy_total <= energy_reg;
            m_data_reg.pair_applied <= applied_reg;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_length_reg    <= ljpfa_pkg::BOX_LENGTH_RST;
            cutoff_sq_reg     <= ljpfa_pkg::CUTOFF_SQ_RST;
            sigma_sq_reg      <= ljpfa_pkg::SIGMA_SQ_RST;
            epsilon_depth_reg <= ljpfa_pkg::EPSILON_DEPTH_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                ljpfa_pkg::CFG_BOX_LENGTH:    box_length_reg    <= cfg_data[30:0];
                ljpfa_pkg::CFG_CUTOFF_SQ:     cutoff_sq_reg     <= cfg_data[30:0];
                ljpfa_pkg::CFG_SIGMA_SQ:      sigma_sq_reg      <= cfg_data[30:0];
                ljpfa_pkg::CFG_EPSILON_DEPTH: epsilon_depth_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // energy total and applied flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_reg  <= '0;
            applied_reg <= 1'b0;
        end else begin
            case (state_reg)
                ljpfa_pkg::S_IDLE: begin
                    if (s_valid) applied_reg <= 1'b0;
                end
                ljpfa_pkg::S_DECODE: begin
                    if (item_reg.func == ljpfa_pkg::FN_ENERGY) energy_reg <= '0;
                end
                ljpfa_pkg::S_UPD_B: begin
                    energy_reg  <= sat48(ext53(energy_reg) + ext53(u_reg));
                    applied_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // item capture and arithmetic datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ljpfa_pkg::S_IDLE: begin
                if (s_valid) begin
                    item_reg <= s_data;
                    r2_reg   <= '0;
                    f_reg[0] <= '0;
                    f_reg[1] <= '0;
                    f_reg[2] <= '0;
                end
            end
            ljpfa_pkg::S_DECODE: begin
                axis_reg <= 2'd0;
                mop_reg  <= ljpfa_pkg::M_SQX;
                d_reg[0] <= 33'(item_reg.pos_a_x) - 33'(item_reg.pos_b_x);
                d_reg[1] <= 33'(item_reg.pos_a_y) - 33'(item_reg.pos_b_y);
                d_reg[2] <= 33'(item_reg.pos_a_z) - 33'(item_reg.pos_b_z);
            end
            ljpfa_pkg::S_MOD_WAIT: begin
                if (div_done_reg) begin
                    d_reg[axis_reg] <= wrap_val;
                    axis_reg        <= axis_reg + 2'd1;
                end
            end
            ljpfa_pkg::S_RANGE: rdiv_reg <= r2_floor[30:0];
            ljpfa_pkg::S_DIVI_WAIT: begin
                if (div_done_reg) inv_reg <= div_q_reg[18:0];
            end
            ljpfa_pkg::S_DIVS_WAIT: begin
                if (div_done_reg) begin
                    s_reg   <= div_q_reg[33:0];
                    mop_reg <= ljpfa_pkg::M_SS;
                end
            end
            ljpfa_pkg::S_MUL_WAIT: begin
                if (mul_done_reg) begin
                    case (mop_reg)
                        ljpfa_pkg::M_SQX: begin
                            r2_reg  <= r2_reg + 49'(mul_res);
                            mop_reg <= ljpfa_pkg::M_SQY;
                        end
                        ljpfa_pkg::M_SQY: begin
                            r2_reg  <= r2_reg + 49'(mul_res);
                            mop_reg <= ljpfa_pkg::M_SQZ;
                        end
                        ljpfa_pkg::M_SQZ: r2_reg <= r2_reg + 49'(mul_res);
                        ljpfa_pkg::M_SS: begin
                            ss_reg  <= mul_res;
                            mop_reg <= ljpfa_pkg::M_SR6;
                        end
                        ljpfa_pkg::M_SR6: begin
                            sr6_reg <= mul_res;
                            mop_reg <= ljpfa_pkg::M_SR12;
                        end
                        ljpfa_pkg::M_SR12: begin
                            sr12_reg <= mul_res;
                            mop_reg  <= ljpfa_pkg::M_ET;
                        end
                        ljpfa_pkg::M_ET: begin
                            // scale by 24
                            fr1_reg <= sat48((mul_sx <<< 4) + (mul_sx <<< 3));
                            mop_reg <= ljpfa_pkg::M_FI;
                        end
                        ljpfa_pkg::M_FI: begin
                            fr2_reg <= mul_sgn;
                            mop_reg <= ljpfa_pkg::M_FX;
                        end
                        ljpfa_pkg::M_FX: begin
                            f_reg[0] <= mul_sgn;
                            mop_reg  <= ljpfa_pkg::M_FY;
                        end
                        ljpfa_pkg::M_FY: begin
                            f_reg[1] <= mul_sgn;
                            mop_reg  <= ljpfa_pkg::M_FZ;
                        end
                        ljpfa_pkg::M_FZ: begin
                            f_reg[2] <= mul_sgn;
                            mop_reg  <= ljpfa_pkg::M_EU;
                        end
                        ljpfa_pkg::M_EU: u_reg <= sat48(mul_sx <<< 2);
                        default: ;
                    endcase
                end
            end
            ljpfa_pkg::S_RD_DATA: begin
                f_reg[0] <= old_x;
                f_reg[1] <= old_y;
                f_reg[2] <= old_z;
            end
            default: ;
        endcase
    end

    // restoring divider, one quotient bit a cycle
    assign div_rem_sh = {div_rem_reg, div_q_reg[47]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
        end else begin
            div_done_reg <= 1'b0;
            if (div_start) begin
                div_busy_reg <= 1'b1;
            end else if (div_busy_reg && div_cnt_reg == DIV_LAST) begin
                div_busy_reg <= 1'b0;
                div_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_start) begin
            div_q_reg   <= div_dvd;
            div_rem_reg <= '0;
            div_dvs_reg <= div_dvs;
            div_cnt_reg <= '0;
        end else if (div_busy_reg) begin
            div_cnt_reg <= div_cnt_reg + 6'd1;
            if (div_rem_sh >= {1'b0, div_dvs_reg}) begin
                div_rem_reg <= 31'(div_rem_sh - {1'b0, div_dvs_reg});
                div_q_reg   <= {div_q_reg[46:0], 1'b1};
            end else begin
                div_rem_reg <= div_rem_sh[30:0];
                div_q_reg   <= {div_q_reg[46:0], 1'b0};
            end
        end
    end

    // multiplier, 48x16 partial products high digit first
    assign mul_pp  = mul_a_reg * mul_b_reg[47:32];
    assign mul_res = (mul_acc_reg[95:63] != '0) ? MAG_MAX : mul_acc_reg[62:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_busy_reg <= 1'b0;
            mul_done_reg <= 1'b0;
        end else begin
            mul_done_reg <= 1'b0;
            if (mul_start) begin
                mul_busy_reg <= 1'b1;
            end else if (mul_busy_reg && mul_cnt_reg == MUL_LAST) begin
                mul_busy_reg <= 1'b0;
                mul_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_start) begin
            mul_a_reg   <= mul_a;
            mul_b_reg   <= mul_b;
            mul_acc_reg <= '0;
            mul_cnt_reg <= '0;
        end else if (mul_busy_reg) begin
            mul_acc_reg <= {mul_acc_reg[79:0], 16'd0} + 96'(mul_pp);
            mul_b_reg   <= {mul_b_reg[31:0], 16'd0};
            mul_cnt_reg <= mul_cnt_reg + 2'd1;
        end
    end

    // force store
    ljpfa_ram #(
        .WIDTH (ljpfa_pkg::ENTRY_W),
        .DEPTH (ljpfa_pkg::MAX_PARTICLES)
    ) u_force_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

`ifndef SYNTH
    // the shared units never run together
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_busy_reg && div_busy_reg))
        else $error("multiplier and divider busy together");

    // one operation in flight
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second beat accepted while busy");

    // store writes only from clear or update steps
    a_ram_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ljpfa_pkg::S_DECODE || state_reg == ljpfa_pkg::S_UPD_A
                    || state_reg == ljpfa_pkg::S_UPD_B))
        else $error("force store written outside an update step");

    // applied flag only for pair operations
    a_applied_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ljpfa_pkg::S_RESP && applied_reg)
            |-> item_reg.func == ljpfa_pkg::FN_PAIR)
        else $error("applied flag on a non-pair operation");

    // multiplier is idle when a step starts
    a_mul_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_busy_reg)
        else $error("multiply started while busy");
`endif

endmodule

// ----- test/tb_lennard_jones_pair_force_accumulator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lennard_jones_pair_force_accumulator
// Self-checking bench for the Lennard-Jones pair force accumulator.
// ----------------------------------------------------------------------------
// A bit-accurate Q15.16 predictor works out each result as the operation is
// queued. A bursty driver feeds input beats, a monitor under a changing
// stall pattern compares every result beat with the oldest prediction. The
// run goes through several register settings, extremes among them, and
// never reads a force entry that was not cleared first.
// ----------------------------------------------------------------------------
module tb_lennard_jones_pair_force_accumulator;

    localparam longint SAT_P    = 64'sh7FFF_FFFF_FFFF;
    localparam longint SAT_N    = -SAT_P - 1;
    localparam int     WD_LIMIT = 20000;
    localparam int     SETTLE   = 400;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    ljpfa_pkg::ljpfa_in_t  s_data;
    logic                  m_valid;
    logic                  m_ready;
    ljpfa_pkg::ljpfa_out_t m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [31:0]           cfg_data;

    lennard_jones_pair_force_accumulator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    longint     fx_mem [ljpfa_pkg::MAX_PARTICLES];
    longint     fy_mem [ljpfa_pkg::MAX_PARTICLES];
    longint     fz_mem [ljpfa_pkg::MAX_PARTICLES];
    bit         cleared [ljpfa_pkg::MAX_PARTICLES];
    longint     energy_sum;
    longint     box_len, cut_sq, sig_sq, eps_d;

    ljpfa_pkg::ljpfa_in_t  pending_ops [$];
    ljpfa_pkg::ljpfa_out_t expected_res [$];

    int  errors;
    int  n_applied, n_results;
    int  idle_cycles;
    int  burst_left, gap_left;
    int  stall_mode, stall_cnt;
    logic s_fire;

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ---------------- fixed point helpers ----------------
    function automatic longint clip48(longint v);
        if (v > SAT_P) return SAT_P;
        if (v < SAT_N) return SAT_N;
        return v;
    endfunction

    function automatic longint umul_q(longint a, longint b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> 16;
        if (p > 128'(SAT_P)) return SAT_P;
        return longint'(p[63:0]);
    endfunction

    function automatic longint smul_q(longint a, longint b);
        longint m;
        m = umul_q(a < 0 ? -a : a, b < 0 ? -b : b);
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic longint min_image(longint d);
        if (box_len == 0) return d;
        d = d % box_len;
        if (d < 0) d += box_len;
        if (2 * d > box_len) d -= box_len;
        return d;
    endfunction

    // expected result of one operation, updating the predictor state
    function automatic ljpfa_pkg::ljpfa_out_t lj_predict(ljpfa_pkg::ljpfa_in_t it);
        ljpfa_pkg::ljpfa_out_t o;
        longint f[3], d[3], pa[3], pb[3];
        longint r2, inv, s, sr6, sr12, t, fr, u;
        int ia, ib;
        ia = it.index_a;
        ib = it.index_b;
        f = '{0, 0, 0};
        o = '0;
        pa = '{longint'(it.pos_a_x), longint'(it.pos_a_y), longint'(it.pos_a_z)};
        pb = '{longint'(it.pos_b_x), longint'(it.pos_b_y), longint'(it.pos_b_z)};
        case (it.func)
            ljpfa_pkg::FN_CLEAR: begin
                fx_mem[ia] = 0; fy_mem[ia] = 0; fz_mem[ia] = 0;
            end
            ljpfa_pkg::FN_READ: begin
                f = '{fx_mem[ia], fy_mem[ia], fz_mem[ia]};
            end
            ljpfa_pkg::FN_ENERGY: energy_sum = 0;
            default: begin
                if (ib > ia) begin
                    r2 = 0;
                    for (int k = 0; k < 3; k++) begin
                        d[k] = min_image(pa[k] - pb[k]);
                        r2 += umul_q(d[k] < 0 ? -d[k] : d[k], d[k] < 0 ? -d[k] : d[k]);
                    end
                    if (r2 < 13107) r2 = 13107;
                    if (r2 <= cut_sq) begin
                        inv = (64'sd1 <<< 32) / r2;
                        s = (sig_sq <<< 16) / r2;
                        if (s > SAT_P) s = SAT_P;
                        sr6 = umul_q(umul_q(s, s), s);
                        sr12 = umul_q(sr6, sr6);
                        t = clip48(2 * sr12 - sr6);
                        fr = clip48(smul_q(eps_d, t) * 24);
                        fr = smul_q(fr, inv);
                        for (int k = 0; k < 3; k++) f[k] = smul_q(fr, d[k]);
                        fx_mem[ia] = clip48(fx_mem[ia] + f[0]);
                        fy_mem[ia] = clip48(fy_mem[ia] + f[1]);
                        fz_mem[ia] = clip48(fz_mem[ia] + f[2]);
                        fx_mem[ib] = clip48(fx_mem[ib] - f[0]);
                        fy_mem[ib] = clip48(fy_mem[ib] - f[1]);
                        fz_mem[ib] = clip48(fz_mem[ib] - f[2]);
                        u = clip48(smul_q(eps_d, clip48(sr12 - sr6)) * 4);
                        energy_sum = clip48(energy_sum + u);
                        o.pair_applied = 1'b1;
                    end
                end
            end
        endcase
        o.out_force_x  = f[0][47:0];
        o.out_force_y  = f[1][47:0];
        o.out_force_z  = f[2][47:0];
        o.energy_total = energy_sum[47:0];
        return o;
    endfunction

    // ---------------- stimulus building ----------------
    task automatic push_op(ljpfa_pkg::ljpfa_in_t it);
        pending_ops.push_back(it);
        expected_res.push_back(lj_predict(it));
    endtask

    // queues an operation, first clearing any entry it could read or update
    task automatic queue_op(logic [1:0] fn, int ia, int ib, logic [31:0] pa[3],
                            logic [31:0] pb[3]);
        ljpfa_pkg::ljpfa_in_t it, clr;
        clr = '0;
        clr.func = ljpfa_pkg::FN_CLEAR;
        clr.index_b = 10'($urandom);
        if ((fn == ljpfa_pkg::FN_READ || (fn == ljpfa_pkg::FN_PAIR && ib > ia))
            && !cleared[ia]) begin
            clr.index_a = 10'(ia);
            push_op(clr);
            cleared[ia] = 1'b1;
        end
        if (fn == ljpfa_pkg::FN_PAIR && ib > ia && !cleared[ib]) begin
            clr.index_a = 10'(ib);
            push_op(clr);
            cleared[ib] = 1'b1;
        end
        if (fn == ljpfa_pkg::FN_CLEAR) cleared[ia] = 1'b1;
        it.func = fn;
        it.index_a = 10'(ia);
        it.index_b = 10'(ib);
        it.pos_a_x = pa[0]; it.pos_a_y = pa[1]; it.pos_a_z = pa[2];
        it.pos_b_x = pb[0]; it.pos_b_y = pb[1]; it.pos_b_z = pb[2];
        push_op(it);
    endtask

    task automatic random_ops(int count);
        logic [31:0] pa[3], pb[3];
        int sel, ia, ib;
        logic [1:0] fn;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            ia = ($urandom_range(4) == 0) ? $urandom_range(1023) : $urandom_range(63);
            ib = ($urandom_range(4) == 0) ? $urandom_range(1023) : $urandom_range(63);
            for (int k = 0; k < 3; k++) begin
                pa[k] = $urandom;
                pb[k] = pa[k] + 32'($signed($urandom_range(393216)) - 196608);
            end
            if (sel < 60) begin
                // well-formed near pair
                fn = ljpfa_pkg::FN_PAIR;
                if (ia == ib) ib = (ia + 1) % 1024;
                if (ib < ia) begin int tmp = ia; ia = ib; ib = tmp; end
            end else if (sel < 72) begin
                fn = ljpfa_pkg::FN_PAIR;
                for (int k = 0; k < 3; k++) pb[k] = $urandom;
            end else if (sel < 86) fn = ljpfa_pkg::FN_READ;
            else if (sel < 95) fn = ljpfa_pkg::FN_CLEAR;
            else fn = ljpfa_pkg::FN_ENERGY;
            queue_op(fn, ia, ib, pa, pb);
        end
    endtask

    // register write through the configuration channel
    task automatic set_reg(logic [1:0] idx, logic [30:0] val);
        case (idx)
            ljpfa_pkg::CFG_BOX_LENGTH: box_len = val;
            ljpfa_pkg::CFG_CUTOFF_SQ:  cut_sq  = val;
            ljpfa_pkg::CFG_SIGMA_SQ:   sig_sq  = val;
            default:                   eps_d   = val;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= {1'($urandom), val};
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all(logic [30:0] bl, logic [30:0] cs, logic [30:0] ss,
                           logic [30:0] ep);
        set_reg(ljpfa_pkg::CFG_BOX_LENGTH, bl);
        set_reg(ljpfa_pkg::CFG_CUTOFF_SQ, cs);
        set_reg(ljpfa_pkg::CFG_SIGMA_SQ, ss);
        set_reg(ljpfa_pkg::CFG_EPSILON_DEPTH, ep);
    endtask

    task automatic drain;
        while (pending_ops.size() != 0 || expected_res.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // ---------------- driver ----------------
    always @(posedge aclk) s_fire <= s_valid && s_ready;

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_fire)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
                s_data <= pending_ops.pop_front();
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(16, 1);
                    gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------- receiver stall pattern ----------------
    always @(negedge aclk) begin
        if (stall_cnt == 0) begin
            stall_mode <= $urandom_range(2);
            stall_cnt <= $urandom_range(600, 50);
        end else begin
            stall_cnt <= stall_cnt - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom);
            default: m_ready <= (stall_cnt % 4 == 0);
        endcase
    end

    // ---------------- monitor ----------------
    always @(posedge aclk) begin
        ljpfa_pkg::ljpfa_out_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (expected_res.size() == 0) begin
                $error("result beat with no prediction waiting");
                errors++;
            end else begin
                want = expected_res.pop_front();
                if (m_data.out_force_x !== want.out_force_x) begin
                    $error("out_force_x: expected %0d actual %0d",
                           want.out_force_x, m_data.out_force_x);
                    errors++;
                end
                if (m_data.out_force_y !== want.out_force_y) begin
                    $error("out_force_y: expected %0d actual %0d",
                           want.out_force_y, m_data.out_force_y);
                    errors++;
                end
                if (m_data.out_force_z !== want.out_force_z) begin
                    $error("out_force_z: expected %0d actual %0d",
                           want.out_force_z, m_data.out_force_z);
                    errors++;
                end
                if (m_data.energy_total !== want.energy_total) begin
                    $error("energy_total: expected %0d actual %0d",
                           want.energy_total, m_data.energy_total);
                    errors++;
                end
                if (m_data.pair_applied !== want.pair_applied) begin
                    $error("pair_applied: expected %0b actual %0b",
                           want.pair_applied, m_data.pair_applied);
                    errors++;
                end
                if (want.pair_applied) n_applied++;
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WD_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WD_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- sequence ----------------
    initial begin
        logic [31:0] pa[3], pb[3];
        errors = 0; n_applied = 0; n_results = 0;
        idle_cycles = 0; burst_left = 0; gap_left = 0;
        stall_mode = 0; stall_cnt = 0;
        aresetn = 1'b0; s_valid = 1'b0; s_data = '0; m_ready = 1'b0;
        cfg_valid = 1'b0; cfg_index = ljpfa_pkg::CFG_BOX_LENGTH; cfg_data = '0;
        for (int i = 0; i < ljpfa_pkg::MAX_PARTICLES; i++) begin
            fx_mem[i] = 0; fy_mem[i] = 0; fz_mem[i] = 0; cleared[i] = 1'b0;
        end
        energy_sum = 0;
        box_len = ljpfa_pkg::BOX_LENGTH_RST; cut_sq = ljpfa_pkg::CUTOFF_SQ_RST;
        sig_sq = ljpfa_pkg::SIGMA_SQ_RST; eps_d = ljpfa_pkg::EPSILON_DEPTH_RST;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part under reset settings
        pa = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000};
        pb = '{32'h0002_0000, 32'h0002_8000, 32'h0003_0000};
        queue_op(ljpfa_pkg::FN_CLEAR, 0, 0, pa, pb);
        queue_op(ljpfa_pkg::FN_CLEAR, 1023, 1023, pa, pb);
        queue_op(ljpfa_pkg::FN_PAIR, 0, 1, pa, pb);
        queue_op(ljpfa_pkg::FN_PAIR, 1, 0, pa, pb);        // reversed order, ignored
        queue_op(ljpfa_pkg::FN_PAIR, 5, 5, pa, pb);        // same particle, ignored
        queue_op(ljpfa_pkg::FN_PAIR, 2, 3, pa, pa);        // coincident, r^2 floor
        pb = '{32'h0005_0000, 32'h0002_0000, 32'h0003_0000};
        queue_op(ljpfa_pkg::FN_PAIR, 0, 1023, pa, pb);     // beyond the cutoff
        pa = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        pb = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        queue_op(ljpfa_pkg::FN_PAIR, 1022, 1023, pa, pb);  // extremes through the wrap
        pa = '{32'h0009_8000, 32'h0, 32'h0};
        pb = '{32'h0000_8000, 32'h0, 32'h0};
        queue_op(ljpfa_pkg::FN_PAIR, 1, 2, pa, pb);        // across the box edge
        queue_op(ljpfa_pkg::FN_READ, 0, 1023, pa, pb);
        queue_op(ljpfa_pkg::FN_READ, 1, 0, pa, pb);
        queue_op(ljpfa_pkg::FN_READ, 1023, 0, pa, pb);
        queue_op(ljpfa_pkg::FN_ENERGY, 1023, 1023, pa, pb);
        queue_op(ljpfa_pkg::FN_READ, 2, 0, pa, pb);
        random_ops(110);
        drain();

        // wrap disabled, everything at its top
        set_all(31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        queue_op(ljpfa_pkg::FN_PAIR, 0, 1, pa, pa);
        random_ops(110);
        drain();

        // unit box, zero cutoff and parameters
        set_all(31'd65536, 31'd0, 31'd0, 31'd0);
        random_ops(90);
        drain();

        // largest box, wide cutoff, small parameters
        set_all(31'h7FFF_FFFF, 31'd2000000, 31'd20000, 31'd3000);
        random_ops(110);
        drain();

        // random settings
        for (int ph = 0; ph < 3; ph++) begin
            set_all(31'($urandom_range(1200000, 65536)), 31'($urandom_range(1500000)),
                    31'($urandom_range(200000)), 31'($urandom_range(300000)));
            random_ops(80);
            drain();
        end

        $display("covered %0d result beats, %0d pairs inside the cutoff, over 7 settings",
                 n_results, n_applied);
        if (errors == 0 && expected_res.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- lennard_jones_pair_force_accumulator.f -----
sv/ljpfa_pkg.sv
sv/ljpfa_ram.sv
sv/lennard_jones_pair_force_accumulator.sv
test/tb_lennard_jones_pair_force_accumulator.sv
